[src/gps_gap_linear_fill_unit_assert.svh]
// ----------------------------------------------------------------------------
// GPS gap fill assertion macros
// Short forms for same-cycle and next-cycle implication checks on clk/rst_n.
// ----------------------------------------------------------------------------
`ifndef GPS_GAP_LINEAR_FILL_UNIT_ASSERT_SVH
`define GPS_GAP_LINEAR_FILL_UNIT_ASSERT_SVH

// Same-cycle implication.
`define GGLF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define GGLF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/gglf_pkg.sv]
// ----------------------------------------------------------------------------
// GPS gap fill package
// Widths, codes, controller states and command/status bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gglf_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int ADDR_W      = $clog2(MAX_SAMPLES);
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int TIME_W      = 40;
    localparam int DEG_W       = 41;
    localparam int IDX_W       = 10;
    localparam int SCNT_W      = 11;
    localparam int STAT_W      = 2;
    localparam int DIFF_W      = DEG_W + 1;
    localparam int STEP_W      = TIME_W + 1;
    localparam int PROD_W      = DIFF_W + STEP_W + 1;
    localparam int QUO_W       = 64;
    localparam int CAP_BIT     = 62;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EDGE    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO_DT = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE   = 2'd3;

    localparam logic signed [DEG_W-1:0] MARK_LAT  = 41'sd386547056640;
    localparam logic signed [DEG_W-1:0] MARK_LON  = 41'sd773094113280;
    localparam logic signed [DEG_W-1:0] DEG_LIMIT = 41'sd773094113280;

    typedef enum logic [2:0] {
        RSEL_HOST,
        RSEL_K,
        RSEL_P,
        RSEL_Q,
        RSEL_IDX
    } gglf_rsel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_READ_OUT,
        S_SCAN_I_RD,
        S_SCAN_I_CHK,
        S_SCAN_J_RD,
        S_SCAN_J_CHK,
        S_CLASSIFY,
        S_P_RD,
        S_P_CAP,
        S_Q_CAP,
        S_CHECK,
        S_FILL_RD,
        S_FILL_STEP,
        S_LAT_GO,
        S_LAT_WAIT,
        S_LON_GO,
        S_LON_WAIT,
        S_FILL_WR
    } gglf_state_t;

    typedef enum logic [2:0] {
        MD_IDLE,
        MD_MUL,
        MD_RND,
        MD_DIV,
        MD_DONE
    } gglf_md_state_t;

    typedef struct packed {
        logic       load_wr;
        logic       rd_en;
        gglf_rsel_t rsel;
        logic       rok_cap;
        logic       pass_begin;
        logic       k_inc;
        logic       set_i;
        logic       set_j;
        logic       classify;
        logic       cap_p;
        logic       cap_q;
        logic       cap_step;
        logic       md_go;
        logic       md_lon;
        logic       cap_lat;
        logic       cap_lon;
        logic       fill_wr;
        logic       next_run;
        logic       set_edge_err;
        logic       set_dt_err;
        logic       out_load;
    } gglf_cmd_t;

    typedef struct packed {
        logic k_ge_n;
        logic rd_marker;
        logic i_zero;
        logic i_one;
        logic j_ge_n;
        logic j1_ge_n;
        logic lead;
        logic trail;
        logic q_marker;
        logic dt_zero;
        logic idx_eq_to;
        logic md_done;
        logic out_full;
    } gglf_sts_t;

endpackage

`default_nettype wire

[src/gps_gap_linear_fill_unit.sv]
// ----------------------------------------------------------------------------
// GPS gap linear fill unit
// Stores timestamped positions, fills invalid runs, returns samples by index.
// ----------------------------------------------------------------------------
// A load request (cmd 0) stores one sample; a sample whose latitude is 90
// degrees and longitude 180 degrees marks a gap. The load flagged last
// closes the set and runs the fill pass, during which in_ready stays low:
// the pass reads each sample it scans, and each filled sample goes through
// the single shared multiply-divide unit (a bit-serial multiply and a
// restoring divide, once for latitude and once for longitude). Interior
// gaps are interpolated in time between their neighbors, edge gaps
// extrapolated from the nearest pair; values saturate to +-180 degrees. A
// read request (cmd 1) passes through the store's registered read port and
// the output register; a result waiting at the output does not stop further
// loads. Status reports the pass outcome, or 3 for an index at or beyond
// sample_count. The stores need no clearing after reset; only indices below
// sample_count are defined.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gps_gap_linear_fill_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                cmd,
    input  logic [gglf_pkg::TIME_W-1:0]         sample_time,
    input  logic signed [gglf_pkg::DEG_W-1:0]   latitude,
    input  logic signed [gglf_pkg::DEG_W-1:0]   longitude,
    input  logic                                last,
    input  logic [gglf_pkg::IDX_W-1:0]          read_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [gglf_pkg::DEG_W-1:0]   lat_out,
    output logic signed [gglf_pkg::DEG_W-1:0]   lon_out,
    output logic [gglf_pkg::STAT_W-1:0]         status,
    output logic [gglf_pkg::SCNT_W-1:0]         sample_count
);
    import gglf_pkg::*;

    gglf_cmd_t cmd_bus;
    gglf_sts_t sts_bus;

    // Sequence requests and the fill pass
    gglf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .last     (last),
        .sts_bus  (sts_bus),
        .cmd_bus  (cmd_bus)
    );

    // Hold the stores, the pass indices and the result register
    gglf_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_bus      (cmd_bus),
        .sts_bus      (sts_bus),
        .sample_time  (sample_time),
        .latitude     (latitude),
        .longitude    (longitude),
        .last         (last),
        .read_index   (read_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .lat_out      (lat_out),
        .lon_out      (lon_out),
        .status       (status),
        .sample_count (sample_count)
    );

endmodule

`default_nettype wire

[src/gglf_muldiv.sv]
// ----------------------------------------------------------------------------
// GPS gap fill multiply-divide unit
// round(a * b / c) with ties away from zero: bit-serial multiply, then a
// restoring divide one quotient bit per cycle; quotient capped at 2^62.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gglf_muldiv (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                go,
    input  logic signed [gglf_pkg::DIFF_W-1:0]  a,
    input  logic signed [gglf_pkg::STEP_W-1:0]  b,
    input  logic signed [gglf_pkg::STEP_W-1:0]  c,
    output logic                                done,
    output logic signed [gglf_pkg::QUO_W-1:0]   q
);
    import gglf_pkg::*;

    localparam int HI_W  = PROD_W - STEP_W;
    localparam int MDC_W = $clog2(PROD_W);

    gglf_md_state_t     state_reg, state_next;
    logic [MDC_W-1:0]   cnt_reg, cnt_next;
    logic [DIFF_W-1:0]  ua_reg;
    logic [STEP_W-1:0]  uc_reg;
    logic               neg_reg;
    logic [PROD_W-1:0]  acc_reg, acc_next;
    logic [STEP_W-1:0]  rem_reg, rem_next;

    logic [HI_W:0]      mul_sum;
    logic [STEP_W:0]    trial;
    logic               ge;
    logic               over;
    logic [QUO_W-1:0]   qmag;

    function automatic logic [DIFF_W-1:0] mag_a(input logic signed [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    endfunction

    function automatic logic [STEP_W-1:0] mag_b(input logic signed [STEP_W-1:0] v);
        return v[STEP_W-1] ? STEP_W'(-v) : STEP_W'(v);
    endfunction

    always_comb
    begin
        mul_sum = {1'b0, acc_reg[PROD_W-1:STEP_W]}
                + (acc_reg[0] ? (HI_W + 1)'(ua_reg) : '0);
        trial   = {rem_reg, acc_reg[PROD_W-1]};
        ge      = trial >= {1'b0, uc_reg};
        over    = (|acc_reg[PROD_W-1:CAP_BIT+1])
                | (acc_reg[CAP_BIT] & (|acc_reg[CAP_BIT-1:0]));
        qmag    = over ? (QUO_W'(1) << CAP_BIT) : acc_reg[QUO_W-1:0];
        q       = neg_reg ? -$signed(qmag) : $signed(qmag);
        done    = state_reg == MD_DONE;

        state_next = state_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        unique case (state_reg)
            MD_IDLE:
            begin
                if (go)
                begin
                    acc_next   = PROD_W'(mag_b(b));
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                acc_next = {mul_sum, acc_reg[STEP_W-1:1]};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == MDC_W'(STEP_W - 1))
                begin
                    cnt_next   = '0;
                    state_next = MD_RND;
                end
            end
            MD_RND:
            begin
                acc_next   = acc_reg + PROD_W'(uc_reg >> 1);
                state_next = MD_DIV;
            end
            MD_DIV:
            begin
                rem_next = ge ? STEP_W'(trial - {1'b0, uc_reg}) : trial[STEP_W-1:0];
                acc_next = {acc_reg[PROD_W-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == MDC_W'(PROD_W - 1))
                begin
                    state_next = MD_DONE;
                end
            end
            MD_DONE:
            begin
                state_next = MD_IDLE;
            end
            default:
            begin
                state_next = MD_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MD_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        if (state_reg == MD_IDLE && go)
        begin
            ua_reg  <= mag_a(a);
            uc_reg  <= mag_b(c);
            neg_reg <= a[DIFF_W-1] ^ b[STEP_W-1] ^ c[STEP_W-1];
        end
    end

endmodule

`default_nettype wire

[src/gglf_datapath.sv]
// ----------------------------------------------------------------------------
// GPS gap fill datapath
// Sample stores, set bookkeeping, run indices, slope pair and result port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gglf_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  gglf_pkg::gglf_cmd_t                 cmd_bus,
    output gglf_pkg::gglf_sts_t                 sts_bus,
    input  logic [gglf_pkg::TIME_W-1:0]         sample_time,
    input  logic signed [gglf_pkg::DEG_W-1:0]   latitude,
    input  logic signed [gglf_pkg::DEG_W-1:0]   longitude,
    input  logic                                last,
    input  logic [gglf_pkg::IDX_W-1:0]          read_index,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [gglf_pkg::DEG_W-1:0]   lat_out,
    output logic signed [gglf_pkg::DEG_W-1:0]   lon_out,
    output logic [gglf_pkg::STAT_W-1:0]         status,
    output logic [gglf_pkg::SCNT_W-1:0]         sample_count
);
    import gglf_pkg::*;

    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;
    localparam logic signed [QUO_W-1:0] LIM_HI = QUO_W'(DEG_LIMIT);
    localparam logic signed [QUO_W-1:0] LIM_LO = -LIM_HI;

    logic [TIME_W-1:0]        time_mem [MAX_SAMPLES];
    logic signed [DEG_W-1:0]  lat_mem  [MAX_SAMPLES];
    logic signed [DEG_W-1:0]  lon_mem  [MAX_SAMPLES];

    logic [TIME_W-1:0]        rd_time;
    logic signed [DEG_W-1:0]  rd_lat, rd_lon;

    logic [CNT_W-1:0]         count_reg, count_next;
    logic [STAT_W-1:0]        status_reg, status_next;
    logic                     closed_reg, closed_next;
    logic [CNT_W-1:0]         k_reg, k_next, i_reg, i_next, j_reg, j_next;
    logic [CNT_W-1:0]         idx_reg, idx_next, to_reg, to_next;
    logic [ADDR_W-1:0]        p_reg, p_next, q_reg, q_next;
    logic                     lead_reg, lead_next, trail_reg, trail_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     rok_reg;

    logic [TIME_W-1:0]        tp_reg, tq_reg;
    logic signed [DEG_W-1:0]  latp_reg, latq_reg, lonp_reg, lonq_reg;
    logic                     qmark_reg;
    logic signed [STEP_W-1:0] step_reg;
    logic signed [DEG_W-1:0]  latf_reg, lonf_reg;
    logic signed [DEG_W-1:0]  lat_out_reg, lon_out_reg;
    logic [STAT_W-1:0]        stat_out_reg;
    logic [SCNT_W-1:0]        cnt_out_reg;

    logic [CNT_W-1:0]         eff_cnt;
    logic                     room;
    logic                     store_load;
    logic [ADDR_W-1:0]        rd_addr;
    logic [ADDR_W-1:0]        wr_addr;
    logic                     pos_we;
    logic signed [DEG_W-1:0]  wr_lat, wr_lon;
    logic [TIME_W-1:0]        ta;
    logic signed [DEG_W-1:0]  lat_a, lon_a;
    logic signed [STEP_W-1:0] dt;
    logic signed [DIFF_W-1:0] dlat, dlon;
    logic                     md_done;
    logic signed [QUO_W-1:0]  md_q;

    function automatic logic signed [DEG_W-1:0] clamp_add(
        input logic signed [DEG_W-1:0] base,
        input logic signed [QUO_W-1:0] off
    );
        logic signed [QUO_W-1:0] sum;
        sum = QUO_W'(base) + off;
        if (sum > LIM_HI)
        begin
            sum = LIM_HI;
        end
        else if (sum < LIM_LO)
        begin
            sum = LIM_LO;
        end
        return DEG_W'(sum);
    endfunction

    // Load room, address and write selects, slope pair differences and anchor
    always_comb
    begin
        eff_cnt    = closed_reg ? '0 : count_reg;
        room       = eff_cnt < CNT_W'(MAX_SAMPLES);
        store_load = cmd_bus.load_wr && room;

        unique case (cmd_bus.rsel)
            RSEL_HOST: rd_addr = ADDR_W'(read_index);
            RSEL_K:    rd_addr = k_reg[ADDR_W-1:0];
            RSEL_P:    rd_addr = p_reg;
            RSEL_Q:    rd_addr = q_reg;
            RSEL_IDX:  rd_addr = idx_reg[ADDR_W-1:0];
            default:   rd_addr = '0;
        endcase

        pos_we  = store_load || cmd_bus.fill_wr;
        wr_addr = cmd_bus.fill_wr ? idx_reg[ADDR_W-1:0] : eff_cnt[ADDR_W-1:0];
        wr_lat  = cmd_bus.fill_wr ? latf_reg : latitude;
        wr_lon  = cmd_bus.fill_wr ? lonf_reg : longitude;

        ta    = trail_reg ? tq_reg : tp_reg;
        lat_a = trail_reg ? latq_reg : latp_reg;
        lon_a = trail_reg ? lonq_reg : lonp_reg;
        dt    = $signed({1'b0, tq_reg}) - $signed({1'b0, tp_reg});
        dlat  = DIFF_W'(latq_reg) - DIFF_W'(latp_reg);
        dlon  = DIFF_W'(lonq_reg) - DIFF_W'(lonp_reg);
    end

    // Set bookkeeping and pass indices
    always_comb
    begin
        count_next     = count_reg;
        status_next    = status_reg;
        closed_next    = closed_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        idx_next       = idx_reg;
        to_next        = to_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        lead_next      = lead_reg;
        trail_next     = trail_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd_bus.load_wr)
        begin
            count_next  = eff_cnt + CNT_W'(room);
            closed_next = last;
            if (closed_reg)
            begin
                status_next = STAT_OK;
            end
        end
        if (cmd_bus.pass_begin)
        begin
            k_next      = '0;
            status_next = STAT_OK;
        end
        if (cmd_bus.k_inc)
        begin
            k_next = k_reg + 1'b1;
        end
        if (cmd_bus.set_i)
        begin
            i_next = k_reg;
            k_next = k_reg + 1'b1;
        end
        if (cmd_bus.set_j)
        begin
            j_next = k_reg;
        end
        if (cmd_bus.next_run)
        begin
            k_next = j_reg;
        end
        if (cmd_bus.classify)
        begin
            lead_next  = i_reg == '0;
            trail_next = (i_reg != '0) && (j_reg >= count_reg);
            if (i_reg == '0)
            begin
                p_next   = j_reg[ADDR_W-1:0];
                q_next   = ADDR_W'(j_reg + 1'b1);
                idx_next = '0;
                to_next  = j_reg;
            end
            else if (j_reg >= count_reg)
            begin
                p_next   = ADDR_W'(i_reg - 2'd2);
                q_next   = ADDR_W'(i_reg - 1'b1);
                idx_next = i_reg;
                to_next  = count_reg;
            end
            else
            begin
                p_next   = ADDR_W'(i_reg - 1'b1);
                q_next   = j_reg[ADDR_W-1:0];
                idx_next = i_reg;
                to_next  = j_reg;
            end
        end
        if (cmd_bus.fill_wr)
        begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmd_bus.set_edge_err)
        begin
            status_next = STAT_EDGE;
        end
        if (cmd_bus.set_dt_err)
        begin
            status_next = STAT_ZERO_DT;
        end
        if (cmd_bus.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            status_reg    <= STAT_OK;
            closed_reg    <= 1'b0;
            k_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            idx_reg       <= '0;
            to_reg        <= '0;
            p_reg         <= '0;
            q_reg         <= '0;
            lead_reg      <= 1'b0;
            trail_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            status_reg    <= status_next;
            closed_reg    <= closed_next;
            k_reg         <= k_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            idx_reg       <= idx_next;
            to_reg        <= to_next;
            p_reg         <= p_next;
            q_reg         <= q_next;
            lead_reg      <= lead_next;
            trail_reg     <= trail_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Sample stores: one write port, one registered read port each
    always_ff @(posedge clk)
    begin
        if (store_load)
        begin
            time_mem[eff_cnt[ADDR_W-1:0]] <= sample_time;
        end
        if (cmd_bus.rd_en)
        begin
            rd_time <= time_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            lat_mem[wr_addr] <= wr_lat;
        end
        if (cmd_bus.rd_en)
        begin
            rd_lat <= lat_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            lon_mem[wr_addr] <= wr_lon;
        end
        if (cmd_bus.rd_en)
        begin
            rd_lon <= lon_mem[rd_addr];
        end
    end

    // Payload captures
    always_ff @(posedge clk)
    begin
        if (cmd_bus.rok_cap)
        begin
            rok_reg <= CMP_W'(read_index) < CMP_W'(count_reg);
        end
        if (cmd_bus.cap_p)
        begin
            tp_reg   <= rd_time;
            latp_reg <= rd_lat;
            lonp_reg <= rd_lon;
        end
        if (cmd_bus.cap_q)
        begin
            tq_reg    <= rd_time;
            latq_reg  <= rd_lat;
            lonq_reg  <= rd_lon;
            qmark_reg <= sts_bus.rd_marker;
        end
        if (cmd_bus.cap_step)
        begin
            step_reg <= $signed({1'b0, rd_time}) - $signed({1'b0, ta});
        end
        if (cmd_bus.cap_lat)
        begin
            latf_reg <= clamp_add(lat_a, md_q);
        end
        if (cmd_bus.cap_lon)
        begin
            lonf_reg <= clamp_add(lon_a, md_q);
        end
        if (cmd_bus.out_load)
        begin
            lat_out_reg  <= rok_reg ? rd_lat : '0;
            lon_out_reg  <= rok_reg ? rd_lon : '0;
            stat_out_reg <= rok_reg ? status_reg : STAT_RANGE;
            cnt_out_reg  <= SCNT_W'(count_reg);
        end
    end

    gglf_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (cmd_bus.md_go),
        .a     (cmd_bus.md_lon ? dlon : dlat),
        .b     (step_reg),
        .c     (dt),
        .done  (md_done),
        .q     (md_q)
    );

    always_comb
    begin
        sts_bus.k_ge_n    = k_reg >= count_reg;
        sts_bus.rd_marker = (rd_lat == MARK_LAT) && (rd_lon == MARK_LON);
        sts_bus.i_zero    = i_reg == '0;
        sts_bus.i_one     = i_reg == CNT_W'(1);
        sts_bus.j_ge_n    = j_reg >= count_reg;
        sts_bus.j1_ge_n   = ({1'b0, j_reg} + 1'b1) >= {1'b0, count_reg};
        sts_bus.lead      = lead_reg;
        sts_bus.trail     = trail_reg;
        sts_bus.q_marker  = qmark_reg;
        sts_bus.dt_zero   = tq_reg == tp_reg;
        sts_bus.idx_eq_to = idx_reg == to_reg;
        sts_bus.md_done   = md_done;
        sts_bus.out_full  = out_valid_reg && !out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign lat_out      = lat_out_reg;
    assign lon_out      = lon_out_reg;
    assign status       = stat_out_reg;
    assign sample_count = cnt_out_reg;

endmodule

`default_nettype wire

[src/gglf_ctrl.sv]
// ----------------------------------------------------------------------------
// GPS gap fill controller
// Request handling and the run-by-run fill pass sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gglf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 cmd,
    input  logic                 last,
    input  gglf_pkg::gglf_sts_t  sts_bus,
    output gglf_pkg::gglf_cmd_t  cmd_bus
);
    import gglf_pkg::*;

    gglf_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        cmd_bus    = '0;
        cmd_bus.rsel = RSEL_HOST;
        in_ready   = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (cmd == CMD_READ)
                    begin
                        cmd_bus.rd_en   = 1'b1;
                        cmd_bus.rok_cap = 1'b1;
                        state_next      = S_READ_OUT;
                    end
                    else
                    begin
                        cmd_bus.load_wr = 1'b1;
                        if (last)
                        begin
                            cmd_bus.pass_begin = 1'b1;
                            state_next         = S_SCAN_I_RD;
                        end
                    end
                end
            end
            S_READ_OUT:
            begin
                if (!sts_bus.out_full)
                begin
                    cmd_bus.out_load = 1'b1;
                    state_next       = S_IDLE;
                end
            end
            S_SCAN_I_RD:
            begin
                if (sts_bus.k_ge_n)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd_bus.rd_en = 1'b1;
                    cmd_bus.rsel  = RSEL_K;
                    state_next    = S_SCAN_I_CHK;
                end
            end
            S_SCAN_I_CHK:
            begin
                if (sts_bus.rd_marker)
                begin
                    cmd_bus.set_i = 1'b1;
                    state_next    = S_SCAN_J_RD;
                end
                else
                begin
                    cmd_bus.k_inc = 1'b1;
                    state_next    = S_SCAN_I_RD;
                end
            end
            S_SCAN_J_RD:
            begin
                if (sts_bus.k_ge_n)
                begin
                    cmd_bus.set_j = 1'b1;
                    state_next    = S_CLASSIFY;
                end
                else
                begin
                    cmd_bus.rd_en = 1'b1;
                    cmd_bus.rsel  = RSEL_K;
                    state_next    = S_SCAN_J_CHK;
                end
            end
            S_SCAN_J_CHK:
            begin
                if (sts_bus.rd_marker)
                begin
                    cmd_bus.k_inc = 1'b1;
                    state_next    = S_SCAN_J_RD;
                end
                else
                begin
                    cmd_bus.set_j = 1'b1;
                    state_next    = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                // Leading run with no slope pair, or trailing run after sample 0 only
                priority if (sts_bus.i_zero && (sts_bus.j_ge_n || sts_bus.j1_ge_n))
                begin
                    cmd_bus.set_edge_err = 1'b1;
                    state_next           = S_IDLE;
                end
                else if (!sts_bus.i_zero && sts_bus.j_ge_n && sts_bus.i_one)
                begin
                    cmd_bus.set_edge_err = 1'b1;
                    state_next           = S_IDLE;
                end
                else
                begin
                    cmd_bus.classify = 1'b1;
                    state_next       = S_P_RD;
                end
            end
            S_P_RD:
            begin
                cmd_bus.rd_en = 1'b1;
                cmd_bus.rsel  = RSEL_P;
                state_next    = S_P_CAP;
            end
            S_P_CAP:
            begin
                cmd_bus.cap_p = 1'b1;
                cmd_bus.rd_en = 1'b1;
                cmd_bus.rsel  = RSEL_Q;
                state_next    = S_Q_CAP;
            end
            S_Q_CAP:
            begin
                cmd_bus.cap_q = 1'b1;
                state_next    = S_CHECK;
            end
            S_CHECK:
            begin
                priority if (sts_bus.lead && sts_bus.q_marker)
                begin
                    cmd_bus.set_edge_err = 1'b1;
                    state_next           = S_IDLE;
                end
                else if (sts_bus.dt_zero)
                begin
                    cmd_bus.set_dt_err = 1'b1;
                    state_next         = S_IDLE;
                end
                else
                begin
                    state_next = S_FILL_RD;
                end
            end
            S_FILL_RD:
            begin
                if (sts_bus.idx_eq_to)
                begin
                    if (sts_bus.trail)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd_bus.next_run = 1'b1;
                        state_next       = S_SCAN_I_RD;
                    end
                end
                else
                begin
                    cmd_bus.rd_en = 1'b1;
                    cmd_bus.rsel  = RSEL_IDX;
                    state_next    = S_FILL_STEP;
                end
            end
            S_FILL_STEP:
            begin
                cmd_bus.cap_step = 1'b1;
                state_next       = S_LAT_GO;
            end
            S_LAT_GO:
            begin
                cmd_bus.md_go = 1'b1;
                state_next    = S_LAT_WAIT;
            end
            S_LAT_WAIT:
            begin
                if (sts_bus.md_done)
                begin
                    cmd_bus.cap_lat = 1'b1;
                    state_next      = S_LON_GO;
                end
            end
            S_LON_GO:
            begin
                cmd_bus.md_go  = 1'b1;
                cmd_bus.md_lon = 1'b1;
                state_next     = S_LON_WAIT;
            end
            S_LON_WAIT:
            begin
                cmd_bus.md_lon = 1'b1;
                if (sts_bus.md_done)
                begin
                    cmd_bus.cap_lon = 1'b1;
                    state_next      = S_FILL_WR;
                end
            end
            S_FILL_WR:
            begin
                cmd_bus.fill_wr = 1'b1;
                state_next      = S_FILL_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[src/gglf_checker.sv]
// ----------------------------------------------------------------------------
// GPS gap fill port checker
// Port-level checks on request and result behavior, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "gps_gap_linear_fill_unit_assert.svh"

module gglf_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic                                cmd,
    input  logic                                last,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic signed [gglf_pkg::DEG_W-1:0]   lat_out,
    input  logic signed [gglf_pkg::DEG_W-1:0]   lon_out,
    input  logic [gglf_pkg::STAT_W-1:0]         status,
    input  logic [gglf_pkg::SCNT_W-1:0]         sample_count
);
    import gglf_pkg::*;

    logic busy_req;
    logic range_out;
    logic inrange_out;
    logic out_stall;
    logic zero_pos;
    logic out_held;

    assign busy_req    = in_valid && in_ready && (cmd == CMD_READ || last);
    assign range_out   = out_valid && status == STAT_RANGE;
    assign inrange_out = out_valid && status != STAT_RANGE;
    assign out_stall   = out_valid && !out_ready;
    assign zero_pos    = lat_out == '0 && lon_out == '0;

    always_comb
    begin
        out_held = out_valid;
    end

    // A read or a set-closing load keeps the block busy in the next cycle
    `GGLF_ASSERT_NEXT(a_busy_after_req, busy_req, !in_ready, "no busy cycle after request")

    // An out-of-range read returns zero coordinates
    `GGLF_ASSERT_SAME(a_range_zero, range_out, zero_pos, "out-of-range read with nonzero data")

    // An in-range read implies a nonempty set
    `GGLF_ASSERT_SAME(a_count_nonzero, inrange_out, sample_count != '0, "in-range read, empty set")

    // Hold a stalled result
    `GGLF_ASSERT_NEXT(a_out_hold, out_stall, out_held && $stable(lat_out) && $stable(status), "stalled result changed")

endmodule

bind gps_gap_linear_fill_unit gglf_checker u_gglf_checker (.*);

`default_nettype wire
